@@ rtl/cpsm_pkg.sv @@
// ----------------------------------------------------------------------------
// cpsm_pkg
// Shared widths, constants and handshake structs of the capture period
// speed meter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsm_pkg;

    // Field widths
    localparam int CAP_W    = 16;
    localparam int PERIOD_W = 16;
    localparam int TICK_W   = 16;
    localparam int SPEED_W  = 24;

    // Divider: dividend, divisor and iteration counter widths
    localparam int DIVD_W = 24;
    localparam int DIVS_W = 16;
    localparam int DCNT_W = $clog2(DIVD_W);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // Register index of tick_rate
    localparam logic [REG_IDX_W-1:0] REG_TICK_RATE = '0;

    // Constants
    localparam logic [PERIOD_W-1:0] HIST_RESET      = 16'd65000;
    localparam logic [TICK_W-1:0]   TICK_RATE_RESET = 16'd10000;
    localparam logic [SPEED_W-1:0]  SPEED_SAT       = 24'd16776960;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/cpsm_if.sv @@
// ----------------------------------------------------------------------------
// cpsm_if
// Valid/ready channels of the speed meter: capture input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpsm_in_if;
    logic                      valid;
    logic                      ready;
    logic [cpsm_pkg::CAP_W-1:0] capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink (input valid, input capture_time, output ready);
endinterface

interface cpsm_out_if;
    logic                         valid;
    logic                         ready;
    logic [cpsm_pkg::PERIOD_W-1:0] raw_period;
    logic [cpsm_pkg::PERIOD_W-1:0] mean_period;
    logic [cpsm_pkg::SPEED_W-1:0]  speed_q8;
    logic                         zero_period;

    modport source (output valid, output raw_period, output mean_period,
                    output speed_q8, output zero_period, input ready);
    modport sink (input valid, input raw_period, input mean_period,
                  input speed_q8, input zero_period, output ready);
endinterface

`default_nettype wire

@@ rtl/cpsm_apb_regs.sv @@
// ----------------------------------------------------------------------------
// cpsm_apb_regs
// APB register file holding the tick_rate register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsm_apb_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cpsm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cpsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cpsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [cpsm_pkg::TICK_W-1:0]     tick_rate
);
    import cpsm_pkg::*;

    logic [TICK_W-1:0]    tick_rate_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // Decode word index, ignore byte lane bits
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Hold tick_rate, write on access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= TICK_RATE_RESET;
        end
        else if (wr_en && (reg_idx == REG_TICK_RATE))
        begin
            tick_rate_reg <= pwdata[TICK_W-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_TICK_RATE: prdata = {{(APB_DATA_W-TICK_W){1'b0}}, tick_rate_reg};
            default:       prdata = '0;
        endcase
    end

    assign tick_rate = tick_rate_reg;

endmodule

`default_nettype wire

@@ rtl/cpsm_divider.sv @@
// ----------------------------------------------------------------------------
// cpsm_divider
// Restoring radix-2 divider, one quotient bit per cycle, used over and over
// for the speed computation.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsm_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cpsm_pkg::div_req_t req,
    output cpsm_pkg::div_rsp_t      rsp
);
    import cpsm_pkg::*;

    localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(DIVD_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0] dvd_reg, dvd_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W+1:0] diff;
    logic              fits;

    // Shift in next dividend bit and trial-subtract
    assign trial = {rem_reg, dvd_reg[DIVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits  = !diff[DIVS_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            dvd_next = {dvd_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

`default_nettype wire

@@ rtl/cpsm_history.sv @@
// ----------------------------------------------------------------------------
// cpsm_history
// Period from consecutive captures, circular period history and its running
// sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsm_history #(
    parameter int HISTORY_DEPTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [cpsm_pkg::CAP_W-1:0]    capture_time,
    output logic      [cpsm_pkg::PERIOD_W-1:0] period,
    output logic      [cpsm_pkg::PERIOD_W+$clog2(HISTORY_DEPTH)-1:0] sum
);
    import cpsm_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = PERIOD_W + SLOT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [SUM_W-1:0]  SUM_RESET = SUM_W'(HISTORY_DEPTH * 65000);

    logic [PERIOD_W-1:0] hist_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CAP_W-1:0]    last_reg;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;

    // New period modulo 2^16, swap it into the running sum
    assign period_next = PERIOD_W'(capture_time - last_reg);
    assign sum_next    = sum_reg - {{SLOT_W{1'b0}}, hist_reg[slot_reg]}
                         + {{SLOT_W{1'b0}}, period_next};
    assign slot_next   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= HIST_RESET;
            end
            slot_reg   <= '0;
            last_reg   <= '0;
            sum_reg    <= SUM_RESET;
            period_reg <= '0;
        end
        else if (push)
        begin
            hist_reg[slot_reg] <= period_next;
            slot_reg           <= slot_next;
            last_reg           <= capture_time;
            sum_reg            <= sum_next;
            period_reg         <= period_next;
        end
    end

    assign period = period_reg;
    assign sum    = sum_reg;

endmodule

`default_nettype wire

@@ rtl/capture_period_speed_meter_core.sv @@
// ----------------------------------------------------------------------------
// capture_period_speed_meter_core
// Capture-based tachometer: period, moving-average period and Q.8 speed.
// ----------------------------------------------------------------------------
// Usage:
//   capture : one transfer per sensor edge carries the latched timer value.
//   result  : one transfer per capture with raw_period, mean_period,
//             speed_q8 (tick_rate*256/mean, truncated) and zero_period.
//   APB     : register 0 at byte address 0 holds tick_rate (reset 10000).
//             Write it only while no capture is in flight.
// Flow: the mean comes from the running sum by a constant reciprocal
//   multiply and is registered in S_MEAN; the radix-2 divider then computes
//   the speed, a step skipped when the mean is zero and the speed saturates.
//   capture.ready is low from the capture transfer until the result enters
//   the output register, so no new capture is taken before that.
// Stall: a finished result waits in the output register; a new capture is
//   taken meanwhile, and its own result waits until the output is taken.
// Reset: history entries return to 65000, the last capture and history slot
//   to zero, tick_rate to 10000; the output register is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_period_speed_meter_core #(
    parameter int HISTORY_DEPTH = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cpsm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [cpsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cpsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    cpsm_in_if.sink                              capture,
    cpsm_out_if.source                           result
);
    import cpsm_pkg::*;

    localparam int DEPTH_LOG = $clog2(HISTORY_DEPTH);
    localparam int SUM_W     = PERIOD_W + DEPTH_LOG;
    localparam int RCP_SHIFT = SUM_W + DEPTH_LOG;
    localparam int RCP_W     = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RCP_W;
    // Rounded-up reciprocal of the depth, exact floor for every sum
    localparam logic [RCP_W-1:0] MEAN_RCP =
        RCP_W'(((longint'(1) << RCP_SHIFT) + longint'(HISTORY_DEPTH - 1))
               / longint'(HISTORY_DEPTH));

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_SPEED_GO,
        S_SPEED_WAIT,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [PERIOD_W-1:0] mean_reg, mean_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic                zero_reg, zero_next;
    logic                out_valid_reg, out_valid_next;
    logic [PERIOD_W-1:0] out_raw_reg, out_raw_next;
    logic [PERIOD_W-1:0] out_mean_reg, out_mean_next;
    logic [SPEED_W-1:0]  out_speed_reg, out_speed_next;
    logic                out_zero_reg, out_zero_next;

    logic [TICK_W-1:0]   tick_rate;
    logic                push;
    logic [PERIOD_W-1:0] period;
    logic [SUM_W-1:0]    sum;
    logic [PROD_W-1:0]   mean_prod;
    logic [PERIOD_W-1:0] mean_calc;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic                out_free;

    // Configuration registers
    cpsm_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .tick_rate (tick_rate)
    );

    // Period history and running sum
    assign push = capture.valid && capture.ready;

    cpsm_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .capture_time (capture.capture_time),
        .period       (period),
        .sum          (sum)
    );

    // Truncated mean: sum times reciprocal, keep the integer part
    assign mean_prod = {{RCP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, MEAN_RCP};
    assign mean_calc = mean_prod[RCP_SHIFT +: PERIOD_W];

    // Divider
    cpsm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Feed the divider: tick_rate*256/mean
    always_comb
    begin
        div_req.start    = (state_reg == S_SPEED_GO);
        div_req.dividend = {tick_rate, 8'h00};
        div_req.divisor  = mean_reg;
    end

    assign out_free      = !out_valid_reg || result.ready;
    assign capture.ready = (state_reg == S_IDLE);

    // Sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        mean_next      = mean_reg;
        speed_next     = speed_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_raw_next   = out_raw_reg;
        out_mean_next  = out_mean_reg;
        out_speed_next = out_speed_reg;
        out_zero_next  = out_zero_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (capture.valid)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                mean_next = mean_calc;
                if (mean_calc == '0)
                begin
                    zero_next  = 1'b1;
                    speed_next = SPEED_SAT;
                    state_next = S_DONE;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = S_SPEED_GO;
                end
            end
            S_SPEED_GO:
            begin
                state_next = S_SPEED_WAIT;
            end
            S_SPEED_WAIT:
            begin
                if (div_rsp.done)
                begin
                    speed_next = div_rsp.quotient[SPEED_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_raw_next   = period;
                    out_mean_next  = mean_reg;
                    out_speed_next = speed_reg;
                    out_zero_next  = zero_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg      <= mean_next;
        speed_reg     <= speed_next;
        zero_reg      <= zero_next;
        out_raw_reg   <= out_raw_next;
        out_mean_reg  <= out_mean_next;
        out_speed_reg <= out_speed_next;
        out_zero_reg  <= out_zero_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.raw_period  = out_raw_reg;
    assign result.mean_period = out_mean_reg;
    assign result.speed_q8    = out_speed_reg;
    assign result.zero_period = out_zero_reg;

    // Zero flag tracks a zero mean
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.zero_period == (result.mean_period == '0)))
        else $error("zero_period does not match mean_period");

    // Zero mean saturates the speed
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.zero_period |-> (result.speed_q8 == SPEED_SAT))
        else $error("speed not saturated on zero mean");

    // Divider is never restarted mid-division
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A capture transfer closes the input until its result is out
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        capture.valid && capture.ready |=> !capture.ready)
        else $error("capture accepted during processing");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the capture period speed meter. Capture transfers
// are sent through the valid/ready input channel. A tracker computes period,
// mean, Q.8 speed and the zero flag for each accepted capture. Each result
// transfer is compared field by field, in order, against that prediction.
// tick_rate is changed over APB between phases and read back.
// ----------------------------------------------------------------------------

import cpsm_pkg::*;

typedef struct packed {
    logic [PERIOD_W-1:0] raw_period;
    logic [PERIOD_W-1:0] mean_period;
    logic [SPEED_W-1:0]  speed_q8;
    logic                zero_period;
} speed_reading_t;

// Tracks tick_rate, last capture and period history; holds pending readings
class tacho_tracker;
    localparam int DEPTH      = 4;
    localparam int REPORT_MAX = 10;

    logic [TICK_W-1:0]   tick_rate;
    logic [CAP_W-1:0]    last_capture;
    logic [PERIOD_W-1:0] history [DEPTH];
    int                  slot;
    speed_reading_t      pending_readings [$];
    int                  errors;
    int                  checked;
    int                  captures;

    function new();
        errors   = 0;
        checked  = 0;
        captures = 0;
        tick_rate    = TICK_RATE_RESET;
        last_capture = '0;
        slot         = 0;
        foreach (history[i]) history[i] = HIST_RESET;
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= REPORT_MAX)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Keep only the low 16 bits of the written word
    function void set_tick_rate(logic [APB_DATA_W-1:0] data);
        tick_rate = data[TICK_W-1:0];
    endfunction

    // Work out the reading that an accepted capture causes
    function void note_capture(logic [CAP_W-1:0] stamp);
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W+1:0] sum;
        speed_reading_t      r;
        period = stamp - last_capture;
        history[slot] = period;
        slot = (slot + 1) % DEPTH;
        sum = '0;
        foreach (history[i]) sum += history[i];
        r.raw_period  = period;
        r.mean_period = PERIOD_W'(sum / DEPTH);
        if (r.mean_period == '0) begin
            r.zero_period = 1'b1;
            r.speed_q8    = SPEED_SAT;
        end
        else begin
            r.zero_period = 1'b0;
            r.speed_q8    = {tick_rate, 8'h00} / r.mean_period;
        end
        last_capture = stamp;
        captures++;
        pending_readings.push_back(r);
    endfunction

    // Compare a result transfer with the oldest pending reading
    function void check_result(speed_reading_t got);
        speed_reading_t want;
        if (pending_readings.size() == 0) begin
            report($sformatf("result with no capture pending: raw %0d mean %0d speed %0d zero %0b",
                             got.raw_period, got.mean_period, got.speed_q8, got.zero_period));
            return;
        end
        want = pending_readings.pop_front();
        checked++;
        if (got.raw_period !== want.raw_period || got.mean_period !== want.mean_period ||
            got.speed_q8 !== want.speed_q8 || got.zero_period !== want.zero_period)
            report($sformatf({"reading %0d: expected raw %0d mean %0d speed %0d zero %0b, ",
                              "got raw %0d mean %0d speed %0d zero %0b"},
                             checked, want.raw_period, want.mean_period, want.speed_q8,
                             want.zero_period, got.raw_period, got.mean_period,
                             got.speed_q8, got.zero_period));
    endfunction
endclass

module tb_top;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;  // no register behind this index
    localparam int PHASE_ITEMS = 145;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cpsm_in_if  cap_if ();
    cpsm_out_if res_if ();

    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int               hold_request;
    int               hold_left;
    int               equal_run;
    int               reg_writes;
    logic [CAP_W-1:0] prev_capture;

    tacho_tracker tracker;

    capture_period_speed_meter_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .capture (cap_if),
        .result  (res_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive every input to a known value from time zero
    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cap_if.valid        = 1'b0;
        cap_if.capture_time = '0;
        res_if.ready        = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_request        = 0;
        hold_left           = 0;
        equal_run           = 0;
        reg_writes          = 0;
        prev_capture        = '0;
        tracker             = new();
    end

    // Result side: check each transfer, then choose ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
                tracker.check_result('{res_if.raw_period, res_if.mean_period,
                                       res_if.speed_q8, res_if.zero_period});
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (hold_request > 0)
            begin
                hold_left    = hold_request - 1;
                hold_request = 0;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // APB write: setup cycle, then access until pready
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        if (idx == REG_TICK_RATE)
            tracker.set_tick_rate(data);
    endtask

    // APB read of tick_rate, compared with the tracked value
    task automatic check_tick_rate();
        logic [APB_DATA_W-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_TICK_RATE, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data[TICK_W-1:0] !== tracker.tick_rate)
            tracker.report($sformatf("tick_rate read: expected %0d, got %0d",
                                     tracker.tick_rate, data[TICK_W-1:0]));
    endtask

    // Set tick_rate with junk in the upper bits, poke the spare index, read back
    task automatic set_rate(input logic [TICK_W-1:0] rate);
        reg_write(REG_TICK_RATE, {16'($urandom), rate});
        reg_write(REG_SPARE, $urandom);
        check_tick_rate();
    endtask

    // Offer one capture; keep valid high across back-to-back transfers
    task automatic send_capture(input logic [CAP_W-1:0] stamp);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cap_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        cap_if.valid        <= 1'b1;
        cap_if.capture_time <= stamp;
        do @(posedge clk); while (!cap_if.ready);
        tracker.note_capture(stamp);
        prev_capture = stamp;
    endtask

    // Drop valid and wait until every pending reading has come back
    task automatic drain();
        cap_if.valid <= 1'b0;
        while (tracker.pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Mostly plausible edge spacing, with runs of equal stamps and raw noise
    function automatic logic [CAP_W-1:0] pick_capture();
        int unsigned      roll;
        logic [CAP_W-1:0] step;
        roll = $urandom_range(99);
        if (equal_run > 0)
        begin
            equal_run--;
            step = '0;
        end
        else if (roll < 6)
        begin
            equal_run = $urandom_range(5, 3);
            step = '0;
        end
        else if (roll < 25)
            step = CAP_W'($urandom_range(15));
        else if (roll < 55)
            step = CAP_W'($urandom_range(4095, 16));
        else if (roll < 80)
            step = CAP_W'($urandom_range(65535, 4096));
        else
            return CAP_W'($urandom_range(65535));
        return prev_capture + step;
    endfunction

    initial
    begin
        logic [CAP_W-1:0] reset_run [$];
        logic [CAP_W-1:0] fast_run [$];
        logic [CAP_W-1:0] stopped_run [$];
        logic [TICK_W-1:0] phase_rate [4];
        int unsigned send_pct [4];
        int unsigned recv_pct [4];

        reset_run   = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd40000};
        fast_run    = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1};
        stopped_run = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd100};
        phase_rate  = '{TICK_W'($urandom_range(65534, 2)), 16'hFFFF, 16'd1, TICK_RATE_RESET};
        send_pct    = '{0, 50, 0, 15};
        recv_pct    = '{0, 0, 50, 15};

        // Hold reset, then release it
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_tick_rate();

        // From reset: history full of 65000, equal stamps down to a zero mean,
        // then the largest period and a wrap through zero
        foreach (reset_run[i]) send_capture(reset_run[i]);
        drain();

        // Fastest rate: mean of one gives full scale, then the largest mean
        set_rate(16'hFFFF);
        foreach (fast_run[i]) send_capture(fast_run[i]);
        drain();

        // Zero rate: speed is zero unless the mean is zero
        set_rate(16'd0);
        foreach (stopped_run[i]) send_capture(stopped_run[i]);
        drain();

        // Random phases, each with its own rate and idle/stall mix
        for (int phase = 0; phase < 4; phase++)
        begin
            set_rate(phase_rate[phase]);
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            if (phase == 0)
                hold_request = HOLD_CYCLES;
            repeat (PHASE_ITEMS) send_capture(pick_capture());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_readings.size() != 0)
            tracker.report($sformatf("%0d readings never arrived",
                                     tracker.pending_readings.size()));

        $display("Run covered %0d captures and %0d checked readings, %0d register writes,",
                 tracker.captures, tracker.checked, reg_writes);
        $display("four idle/stall mixes and a %0d-cycle output hold; %0d mismatches counted.",
                 HOLD_CYCLES, tracker.errors);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Give up well past the slowest correct run
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d readings still pending", tracker.pending_readings.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ capture_period_speed_meter_core.f @@
rtl/cpsm_pkg.sv
rtl/cpsm_if.sv
rtl/cpsm_apb_regs.sv
rtl/cpsm_divider.sv
rtl/cpsm_history.sv
rtl/capture_period_speed_meter_core.sv
test/tb_top.sv
